>>> hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants for the first-fit heap allocator: default sizes and
// the status codes returned with every result word.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES_DEF = 65536;
    localparam int MAX_CHUNKS_DEF = 1024;

    localparam logic       FUNC_ALLOC = 1'b0;
    localparam logic       FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

endpackage

>>> hw/rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over heap byte offsets, with address-sorted free and
// allocated chunk tables each held in a synchronous RAM.
//
// Usage:
//   Request words enter on in_valid/in_stall (func, req_size, address); one
//   result word (granted_address, status) leaves on out_valid/out_stall for
//   every request. One request is worked on at a time; in_stall is low only
//   while the block is idle.
//   An allocate makes one pass over the free table (S_A_RD and S_A_PR per
//   entry) that merges touching chunks, takes the first fit and writes back
//   the tail, then a sorted insert into the allocated table (S_I_RD and
//   S_I_PR per shifted entry). A free scans the allocated table, inserts
//   into the free table and closes the gap in the allocated table. Early
//   rejects go from idle straight to the result state S_DONE. After reset
//   the block writes the initial free chunk in S_INIT before going idle.
//   A finished result waits in the output register while out_stall is high;
//   the block accepts the next request meanwhile and holds a newer result
//   until the register frees up.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF,
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [16:0] req_size,
    input  logic [15:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] granted_address,
    output logic [1:0]  status
);

    localparam int AW   = $clog2(HEAP_BYTES);
    localparam int SZW  = $clog2(HEAP_BYTES + 1);
    localparam int CW   = (SZW > 17) ? SZW : 17;
    localparam int AXW  = (AW > 16) ? AW : 16;
    localparam int IW   = $clog2(MAX_CHUNKS);
    localparam int CNTW = $clog2(MAX_CHUNKS + 1);
    localparam int DW   = AW + SZW;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_RD  = 4'd2;
    localparam logic [3:0] S_A_PR  = 4'd3;
    localparam logic [3:0] S_A_END = 4'd4;
    localparam logic [3:0] S_I_RD  = 4'd5;
    localparam logic [3:0] S_I_PR  = 4'd6;
    localparam logic [3:0] S_S_RD  = 4'd7;
    localparam logic [3:0] S_S_PR  = 4'd8;
    localparam logic [3:0] S_R_RD  = 4'd9;
    localparam logic [3:0] S_R_PR  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]      state_reg, state_next;
    logic [CNTW-1:0] i_reg, i_next;
    logic [CNTW-1:0] w_reg, w_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [CNTW-1:0] fcnt_reg, fcnt_next;
    logic [CNTW-1:0] ucnt_reg, ucnt_next;
    logic [AW-1:0]   p_start_reg, p_start_next;
    logic [SZW-1:0]  p_size_reg, p_size_next;
    logic            p_valid_reg, p_valid_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   g_start_reg, g_start_next;
    logic [AW-1:0]   ins_start_reg, ins_start_next;
    logic [SZW-1:0]  ins_size_reg, ins_size_next;
    logic            tsel_reg, tsel_next;
    logic [16:0]     req_reg, req_next;
    logic [15:0]     addr_reg, addr_next;
    logic [15:0]     res_addr_reg, res_addr_next;
    logic [1:0]      res_stat_reg, res_stat_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     out_addr_reg, out_addr_next;
    logic [1:0]      out_stat_reg, out_stat_next;

    logic          f_we, u_we;
    logic [IW-1:0] f_waddr, f_raddr, u_waddr, u_raddr;
    logic [DW-1:0] f_wdata, u_wdata, f_rdata, u_rdata;

    logic [AW-1:0]  e_start;
    logic [SZW-1:0] e_size;
    logic [AW-1:0]  t_start;
    logic [SZW-1:0] t_size;
    logic [CW-1:0]  p_end;
    logic [CW-1:0]  p_size_x;
    logic [CW-1:0]  req_x;
    logic           p_fit;
    logic [AXW-1:0] g_x;
    logic [AXW-1:0] u_start_x;

    ffha_ram #(.WIDTH(DW), .DEPTH(MAX_CHUNKS)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    ffha_ram #(.WIDTH(DW), .DEPTH(MAX_CHUNKS)) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    assign e_start   = f_rdata[DW-1:SZW];
    assign e_size    = f_rdata[SZW-1:0];
    assign t_start   = tsel_reg ? u_rdata[DW-1:SZW] : f_rdata[DW-1:SZW];
    assign t_size    = tsel_reg ? u_rdata[SZW-1:0] : f_rdata[SZW-1:0];
    assign p_size_x  = CW'(p_size_reg);
    assign req_x     = CW'(req_reg);
    assign p_end     = CW'(p_start_reg) + p_size_x;
    assign p_fit     = !found_reg && (p_size_x >= req_x);
    assign g_x       = AXW'(g_start_reg);
    assign u_start_x = AXW'(u_rdata[DW-1:SZW]);

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign status          = out_stat_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        w_next         = w_reg;
        idx_next       = idx_reg;
        fcnt_next      = fcnt_reg;
        ucnt_next      = ucnt_reg;
        p_start_next   = p_start_reg;
        p_size_next    = p_size_reg;
        p_valid_next   = p_valid_reg;
        found_next     = found_reg;
        g_start_next   = g_start_reg;
        ins_start_next = ins_start_reg;
        ins_size_next  = ins_size_reg;
        tsel_next      = tsel_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        res_addr_next  = res_addr_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_stat_next  = out_stat_reg;
        f_we    = 1'b0;
        f_waddr = w_reg[IW-1:0];
        f_wdata = {p_start_reg, p_size_reg};
        f_raddr = i_reg[IW-1:0];
        u_we    = 1'b0;
        u_waddr = i_reg[IW-1:0];
        u_wdata = {ins_start_reg, ins_size_reg};
        u_raddr = i_reg[IW-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                f_we       = 1'b1;
                f_waddr    = '0;
                f_wdata    = {AW'(0), SZW'(HEAP_BYTES)};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_size;
                    addr_next     = address;
                    res_addr_next = '0;
                    i_next        = '0;
                    if (func == FUNC_FREE)
                    begin
                        state_next = S_S_RD;
                    end
                    else if (req_size == '0)
                    begin
                        res_stat_next = ST_NOFIT;
                        state_next    = S_DONE;
                    end
                    else if (ucnt_reg >= CNTW'(MAX_CHUNKS))
                    begin
                        res_stat_next = ST_FULL;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        w_next       = '0;
                        p_valid_next = 1'b0;
                        found_next   = 1'b0;
                        state_next   = S_A_RD;
                    end
                end
            end
            // merge pass over the free table, first fit taken on the fly
            S_A_RD:
            begin
                if (i_reg < fcnt_reg)
                begin
                    state_next = S_A_PR;
                end
                else
                begin
                    state_next = S_A_END;
                end
            end
            S_A_PR:
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_A_RD;
                if (p_valid_reg && (p_end == CW'(e_start)))
                begin
                    p_size_next = p_size_reg + e_size;
                end
                else
                begin
                    if (p_valid_reg)
                    begin
                        if (p_fit)
                        begin
                            found_next   = 1'b1;
                            g_start_next = p_start_reg;
                            if (p_size_x != req_x)
                            begin
                                f_we    = 1'b1;
                                f_wdata = {AW'(CW'(p_start_reg) + req_x),
                                           SZW'(p_size_x - req_x)};
                                w_next  = w_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            f_we   = 1'b1;
                            w_next = w_reg + 1'b1;
                        end
                    end
                    p_start_next = e_start;
                    p_size_next  = e_size;
                    p_valid_next = 1'b1;
                end
            end
            S_A_END:
            begin
                fcnt_next = w_reg;
                if (p_valid_reg)
                begin
                    if (p_fit)
                    begin
                        found_next   = 1'b1;
                        g_start_next = p_start_reg;
                        if (p_size_x != req_x)
                        begin
                            f_we      = 1'b1;
                            f_wdata   = {AW'(CW'(p_start_reg) + req_x),
                                         SZW'(p_size_x - req_x)};
                            fcnt_next = w_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        f_we      = 1'b1;
                        fcnt_next = w_reg + 1'b1;
                    end
                end
                if (found_next)
                begin
                    ins_start_next = g_start_next;
                    ins_size_next  = SZW'(req_reg);
                    tsel_next      = 1'b1;
                    i_next         = ucnt_reg;
                    state_next     = S_I_RD;
                end
                else
                begin
                    res_stat_next = ST_NOFIT;
                    state_next    = S_DONE;
                end
            end
            // sorted insert, shifting larger entries up by one
            S_I_RD:
            begin
                f_raddr = IW'(i_reg - 1'b1);
                u_raddr = IW'(i_reg - 1'b1);
                if (i_reg == '0)
                begin
                    f_waddr = '0;
                    f_wdata = {ins_start_reg, ins_size_reg};
                    u_waddr = '0;
                    f_we    = !tsel_reg;
                    u_we    = tsel_reg;
                    if (tsel_reg)
                    begin
                        ucnt_next     = ucnt_reg + 1'b1;
                        res_stat_next = ST_OK;
                        res_addr_next = g_x[15:0];
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        fcnt_next  = fcnt_reg + 1'b1;
                        i_next     = idx_reg;
                        state_next = S_R_RD;
                    end
                end
                else
                begin
                    state_next = S_I_PR;
                end
            end
            S_I_PR:
            begin
                f_waddr = i_reg[IW-1:0];
                u_waddr = i_reg[IW-1:0];
                f_we    = !tsel_reg;
                u_we    = tsel_reg;
                if (t_start > ins_start_reg)
                begin
                    f_wdata    = {t_start, t_size};
                    u_wdata    = {t_start, t_size};
                    i_next     = i_reg - 1'b1;
                    state_next = S_I_RD;
                end
                else
                begin
                    f_wdata = {ins_start_reg, ins_size_reg};
                    if (tsel_reg)
                    begin
                        ucnt_next     = ucnt_reg + 1'b1;
                        res_stat_next = ST_OK;
                        res_addr_next = g_x[15:0];
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        fcnt_next  = fcnt_reg + 1'b1;
                        i_next     = idx_reg;
                        state_next = S_R_RD;
                    end
                end
            end
            // search the allocated table for the freed address
            S_S_RD:
            begin
                if (i_reg < ucnt_reg)
                begin
                    state_next = S_S_PR;
                end
                else
                begin
                    res_stat_next = ST_UNKNOWN;
                    state_next    = S_DONE;
                end
            end
            S_S_PR:
            begin
                if (u_start_x == AXW'(addr_reg))
                begin
                    if (fcnt_reg >= CNTW'(MAX_CHUNKS))
                    begin
                        res_stat_next = ST_FULL;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        ins_start_next = u_rdata[DW-1:SZW];
                        ins_size_next  = u_rdata[SZW-1:0];
                        idx_next       = i_reg;
                        tsel_next      = 1'b0;
                        i_next         = fcnt_reg;
                        state_next     = S_I_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_S_RD;
                end
            end
            // close the gap in the allocated table
            S_R_RD:
            begin
                u_raddr = IW'(i_reg + 1'b1);
                if ((CNTW'(i_reg + 1'b1)) < ucnt_reg)
                begin
                    state_next = S_R_PR;
                end
                else
                begin
                    ucnt_next     = ucnt_reg - 1'b1;
                    res_stat_next = ST_OK;
                    state_next    = S_DONE;
                end
            end
            S_R_PR:
            begin
                u_we       = 1'b1;
                u_waddr    = i_reg[IW-1:0];
                u_wdata    = u_rdata;
                i_next     = i_reg + 1'b1;
                state_next = S_R_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            fcnt_reg      <= CNTW'(1);
            ucnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            w_reg         <= '0;
            p_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            tsel_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            ucnt_reg      <= ucnt_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            w_reg         <= w_next;
            p_valid_reg   <= p_valid_next;
            found_reg     <= found_next;
            tsel_reg      <= tsel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        p_start_reg   <= p_start_next;
        p_size_reg    <= p_size_next;
        g_start_reg   <= g_start_next;
        ins_start_reg <= ins_start_next;
        ins_size_reg  <= ins_size_next;
        req_reg       <= req_next;
        addr_reg      <= addr_next;
        res_addr_reg  <= res_addr_next;
        res_stat_reg  <= res_stat_next;
        out_addr_reg  <= out_addr_next;
        out_stat_reg  <= out_stat_next;
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_heap_allocator. An initial block builds
// the request words and, in the same order, runs a behavioral model of the
// free and allocated chunk tables to produce the expected result words. A
// clocked driver feeds the requests with random idle bursts. A clocked
// monitor stalls the output at random and checks every result word against
// the oldest expectation.
// ----------------------------------------------------------------------------
module tb;
    import ffha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP   = HEAP_BYTES_DEF;
    localparam int CHUNKS = MAX_CHUNKS_DEF;
    localparam int FREE_T = 0;
    localparam int USED_T = 1;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct {
        logic        func;
        logic [16:0] size;
        logic [15:0] addr;
        bit          hold;
    } req_word_t;

    typedef struct {
        logic [15:0] granted;
        logic [1:0]  st;
    } grant_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [16:0] req_size;
    logic [15:0] address;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] granted_address;
    logic [1:0]  status;

    req_word_t   pending_reqs[$];
    grant_word_t expected_grants[$];
    int          chunk_start[2][CHUNKS];
    int          chunk_size[2][CHUNKS];
    int          chunk_count[2];
    int          n_sent;
    int          n_got;
    int          n_err;
    int          send_gap;
    int          stall_gap;
    longint      cyc;
    bit          stim_done;

    first_fit_heap_allocator uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .req_size(req_size),
        .address(address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .granted_address(granted_address),
        .status(status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void chunk_insert(int t, int s, int n);
        int i;
        i = chunk_count[t];
        while (i > 0 && chunk_start[t][i-1] > s)
        begin
            chunk_start[t][i] = chunk_start[t][i-1];
            chunk_size[t][i]  = chunk_size[t][i-1];
            i--;
        end
        chunk_start[t][i] = s;
        chunk_size[t][i]  = n;
        chunk_count[t]++;
    endfunction

    function automatic void chunk_remove(int t, int idx);
        for (int i = idx; i + 1 < chunk_count[t]; i++)
        begin
            chunk_start[t][i] = chunk_start[t][i+1];
            chunk_size[t][i]  = chunk_size[t][i+1];
        end
        chunk_count[t]--;
    endfunction

    function automatic void merge_free_chunks();
        int i;
        i = 0;
        while (i + 1 < chunk_count[FREE_T])
        begin
            if (chunk_start[FREE_T][i] + chunk_size[FREE_T][i] == chunk_start[FREE_T][i+1])
            begin
                chunk_size[FREE_T][i] += chunk_size[FREE_T][i+1];
                chunk_remove(FREE_T, i + 1);
            end
            else
                i++;
        end
    endfunction

    function automatic grant_word_t heap_predict(logic f, int sz, int ad);
        grant_word_t r;
        int          s;
        int          tail;
        r.granted = '0;
        if (f == FUNC_ALLOC)
        begin
            r.st = ST_NOFIT;
            if (sz != 0 && chunk_count[USED_T] >= CHUNKS)
                r.st = ST_FULL;
            else if (sz != 0)
            begin
                merge_free_chunks();
                for (int i = 0; i < chunk_count[FREE_T]; i++)
                begin
                    if (chunk_size[FREE_T][i] >= sz)
                    begin
                        s    = chunk_start[FREE_T][i];
                        tail = chunk_size[FREE_T][i] - sz;
                        chunk_remove(FREE_T, i);
                        chunk_insert(USED_T, s, sz);
                        if (tail > 0)
                            chunk_insert(FREE_T, s + sz, tail);
                        r.granted = s[15:0];
                        r.st = ST_OK;
                        break;
                    end
                end
            end
        end
        else
        begin
            r.st = ST_UNKNOWN;
            for (int i = 0; i < chunk_count[USED_T]; i++)
            begin
                if (chunk_start[USED_T][i] == ad)
                begin
                    if (chunk_count[FREE_T] >= CHUNKS)
                        r.st = ST_FULL;
                    else
                    begin
                        chunk_insert(FREE_T, chunk_start[USED_T][i], chunk_size[USED_T][i]);
                        chunk_remove(USED_T, i);
                        r.st = ST_OK;
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic queue_req(logic f, int sz, int ad, bit hold);
        req_word_t w;
        w.func = f;
        w.size = sz[16:0];
        w.addr = ad[15:0];
        w.hold = hold;
        pending_reqs.push_back(w);
        expected_grants.push_back(heap_predict(f, sz, ad));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= FUNC_ALLOC;
            req_size <= '0;
            address  <= '0;
            send_gap <= 0;
            n_sent   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                n_sent <= n_sent + 1;
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 30 && (cyc / 700) % 3 != 0
                         && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !(pending_reqs[0].hold
                         && (n_got != n_sent + ((in_valid && !in_stall) ? 1 : 0)
                             || in_valid)))
                begin
                    in_valid <= 1'b1;
                    func     <= pending_reqs[0].func;
                    req_size <= pending_reqs[0].size;
                    address  <= pending_reqs[0].addr;
                    void'(pending_reqs.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        grant_word_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_gap <= 0;
            n_got     <= 0;
            n_err     <= 0;
            cyc       <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (out_valid && !out_stall)
            begin
                n_got <= n_got + 1;
                if (n_got >= n_sent || expected_grants.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h/%0d",
                             $realtime, granted_address, status);
                    n_err <= n_err + 1;
                end
                else
                begin
                    e = expected_grants.pop_front();
                    if (granted_address !== e.granted || status !== e.st)
                    begin
                        $display("%0t: mismatch: expected %h/%0d, actual %h/%0d",
                                 $realtime, e.granted, e.st, granted_address, status);
                        n_err <= n_err + 1;
                    end
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap <= stall_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!stim_done && pending_reqs.size() > 30 && (cyc / 900) % 3 != 1
                     && $urandom_range(0, 7) == 0)
            begin
                stall_gap <= $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
            if (cyc >= CYCLE_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int ui;
        int sz;
        rst_n     = 1'b0;
        stim_done = 1'b0;
        chunk_start[FREE_T][0] = 0;
        chunk_size[FREE_T][0]  = HEAP;
        chunk_count[FREE_T]    = 1;
        chunk_count[USED_T]    = 0;

        queue_req(FUNC_ALLOC, 0, 16'hffff, 0);
        queue_req(FUNC_ALLOC, 131071, 0, 0);
        queue_req(FUNC_ALLOC, 65537, 0, 0);
        queue_req(FUNC_ALLOC, 65536, 16'h5555, 0);
        queue_req(FUNC_ALLOC, 1, 0, 0);
        queue_req(FUNC_FREE, 131071, 16'hffff, 0);
        queue_req(FUNC_FREE, 0, 0, 0);
        queue_req(FUNC_ALLOC, 100, 0, 0);
        queue_req(FUNC_ALLOC, 200, 0, 0);
        queue_req(FUNC_ALLOC, 300, 0, 0);
        queue_req(FUNC_FREE, 0, 100, 0);
        queue_req(FUNC_FREE, 0, 16'haaaa, 0);
        queue_req(FUNC_ALLOC, 200, 0, 0);
        queue_req(FUNC_FREE, 0, 0, 0);
        queue_req(FUNC_FREE, 0, 300, 0);
        queue_req(FUNC_FREE, 0, 100, 0);
        queue_req(FUNC_ALLOC, 65536, 0, 0);
        queue_req(FUNC_FREE, 0, 0, 0);

        for (int n = 0; n < 272; n++)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                case ($urandom_range(0, 19))
                    0:       sz = 0;
                    1:       sz = $urandom_range(1, 131071);
                    2:       sz = $urandom_range(8192, 40000);
                    default: sz = $urandom_range(1, 2048);
                endcase
                queue_req(FUNC_ALLOC, sz, $urandom_range(0, 65535), n == 0);
            end
            else if (chunk_count[USED_T] > 0 && $urandom_range(0, 4) != 0)
            begin
                ui = $urandom_range(0, chunk_count[USED_T] - 1);
                queue_req(FUNC_FREE, $urandom_range(0, 131071), chunk_start[USED_T][ui],
                          n == 0);
            end
            else
                queue_req(FUNC_FREE, $urandom_range(0, 131071), $urandom_range(0, 65535),
                          n == 0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0);
        @(posedge clk);
        wait (!in_valid && n_got == n_sent);
        stim_done = 1'b1;
        repeat (200) @(posedge clk);
        if (n_err == 0 && expected_grants.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
